[hw/rtl/tttr_dec_pkg.sv]
// ----------------------------------------------------------------------------
// TTTR record decoder package
// Record layouts, event kinds, wrap periods and port widths shared by the
// photon record decoder.
// ----------------------------------------------------------------------------
package tttr_dec_pkg;

  localparam int unsigned RECORD_W    = 32;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned OUT_TICK_W  = 64;
  localparam int unsigned CODE_W      = 12;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned CHAN_W      = 7;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_SELECTED = 3'd0,
    KIND_OTHER    = 3'd1,
    KIND_MARKER   = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_IGNORED  = 3'd4
  } event_kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SINGLE_T2   = 3'd0,
    MODE_SINGLE_T3   = 3'd1,
    MODE_MULTI_T2_V1 = 3'd2,
    MODE_MULTI_T3_V1 = 3'd3,
    MODE_MULTI_T2_V2 = 3'd4,
    MODE_MULTI_T3_V2 = 3'd5,
    MODE_UNUSED_6    = 3'd6,
    MODE_UNUSED_7    = 3'd7
  } decoder_mode_t;

  localparam logic [CFG_INDEX_W-1:0] REG_DECODER_MODE     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DETECTOR_CHANNEL = 8'd1;

  localparam logic [CHAN_W-1:0] DETECTOR_CHANNEL_RESET = 7'd1;

  localparam logic [63:0] WRAP_SINGLE_T2   = 64'd210698240;
  localparam logic [63:0] WRAP_SINGLE_T3   = 64'd65536;
  localparam logic [63:0] WRAP_MULTI_T2_V1 = 64'd33552000;
  localparam logic [63:0] WRAP_MULTI_T2_V2 = 64'd33554432;
  localparam logic [63:0] WRAP_MULTI_T3    = 64'd1024;

  localparam logic [3:0] SINGLE_SPECIAL_CH = 4'hf;
  localparam logic [5:0] MULTI_OVERFLOW_CH = 6'h3f;
  localparam logic [5:0] MULTI_MARKER_MAX  = 6'd15;

endpackage

[hw/rtl/tttr_photon_record_decoder.sv]
// ----------------------------------------------------------------------------
// TTTR photon record decoder
// Decodes 32-bit time-tagged records in six layouts, tracks the overflow
// accumulator and reports event kind, absolute tick and channel or marker.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  in_      slave      one raw record per request
//  out_     master     event kind, absolute tick, event code
//  cfg_     slave      register index and write data
//
// One record per cycle sustained while the output is not stalled; a record
// is registered in the input register, then in the result register. The
// single accumulator add lies between the two registers.
// Reset clears the accumulator, selects mode 0 and detector channel 1.
// A stalled output holds its result; the input register keeps taking records
// until both registers are full.
module tttr_photon_record_decoder
  import tttr_dec_pkg::*;
#(
  parameter int unsigned TICK_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] record_word
  input  logic [RECORD_W-1:0]    in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] event_kind, [66:3] abs_tick, [78:67] event_code, [79] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                 s1_valid_r;
  logic [RECORD_W-1:0]  s1_rec_r;
  logic                 out_valid_r;
  event_kind_t          out_kind_r;
  logic [OUT_TICK_W-1:0] out_tick_r;
  logic [CODE_W-1:0]    out_code_r;
  logic [TICK_BITS-1:0] accum_r;
  logic [TICK_BITS-1:0] accum_nxt;
  decoder_mode_t        mode_r;
  logic [CHAN_W-1:0]    det_r;

  logic                 s1_advance;
  logic                 in_fire;
  event_kind_t          kind_nxt;
  logic [CODE_W-1:0]    code_nxt;
  logic [63:0]          addend64;
  logic [TICK_BITS-1:0] tick_sum;
  logic [OUT_TICK_W-1:0] tick_nxt;
  logic                 is_overflow;
  logic                 is_ignored;
  logic [CHAN_W-1:0]    photon_ch;
  logic                 is_photon;

  logic [3:0]  sch;
  logic [5:0]  mch;
  logic        special;
  logic [24:0] mt;
  logic [9:0]  mns;

  assign cfg_ready  = 1'b1;
  assign s1_advance = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_fire    = in_tvalid && in_tready;

  assign sch     = s1_rec_r[31:28];
  assign mch     = s1_rec_r[30:25];
  assign special = s1_rec_r[31];
  assign mt      = s1_rec_r[24:0];
  assign mns     = s1_rec_r[9:0];

  always_comb begin
    addend64    = 64'd0;
    code_nxt    = '0;
    is_overflow = 1'b0;
    is_ignored  = 1'b0;
    is_photon   = 1'b0;
    photon_ch   = '0;
    kind_nxt    = KIND_MARKER;
    case (mode_r)
      MODE_SINGLE_T2: begin
        if (sch != SINGLE_SPECIAL_CH) begin
          is_photon = 1'b1;
          photon_ch = {3'd0, sch};
          addend64  = {36'd0, s1_rec_r[27:0]};
        end else if (s1_rec_r[3:0] == 4'd0) begin
          is_overflow = 1'b1;
          addend64    = WRAP_SINGLE_T2;
        end else begin
          code_nxt = {8'd0, s1_rec_r[3:0]};
          addend64 = {36'd0, s1_rec_r[27:4], 4'd0};
        end
      end
      MODE_SINGLE_T3: begin
        addend64 = {48'd0, s1_rec_r[15:0]};
        if (sch != SINGLE_SPECIAL_CH) begin
          is_photon = 1'b1;
          photon_ch = {3'd0, sch};
        end else if (s1_rec_r[27:16] == 12'd0) begin
          is_overflow = 1'b1;
          addend64    = WRAP_SINGLE_T3;
        end else begin
          code_nxt = s1_rec_r[27:16];
        end
      end
      MODE_MULTI_T2_V1, MODE_MULTI_T2_V2: begin
        addend64 = {39'd0, mt};
        if (!special) begin
          is_photon = 1'b1;
          photon_ch = {1'b0, mch} + 7'd1;
        end else if (mch == MULTI_OVERFLOW_CH) begin
          is_overflow = 1'b1;
          if (mode_r == MODE_MULTI_T2_V1) begin
            addend64 = WRAP_MULTI_T2_V1;
          end else if (mt == 25'd0) begin
            addend64 = WRAP_MULTI_T2_V2;
          end else begin
            addend64 = {14'd0, mt, 25'd0};
          end
        end else if (mch != 6'd0 && mch <= MULTI_MARKER_MAX) begin
          code_nxt = {6'd0, mch};
        end else if (mch == 6'd0) begin
          is_photon = 1'b1;
          photon_ch = '0;
        end else begin
          is_ignored = 1'b1;
        end
      end
      MODE_MULTI_T3_V1, MODE_MULTI_T3_V2: begin
        addend64 = {54'd0, mns};
        if (!special) begin
          is_photon = 1'b1;
          photon_ch = {1'b0, mch};
        end else if (mch == MULTI_OVERFLOW_CH) begin
          is_overflow = 1'b1;
          if (mode_r == MODE_MULTI_T3_V1 || mns == 10'd0) begin
            addend64 = WRAP_MULTI_T3;
          end else begin
            addend64 = {44'd0, mns, 10'd0};
          end
        end else if (mch != 6'd0 && mch <= MULTI_MARKER_MAX) begin
          code_nxt = {6'd0, mch};
        end else begin
          is_ignored = 1'b1;
        end
      end
      default: begin
        is_ignored = 1'b1;
      end
    endcase

    tick_sum = accum_r + addend64[TICK_BITS-1:0];
    tick_nxt = OUT_TICK_W'(tick_sum);

    if (is_photon) begin
      code_nxt = {5'd0, photon_ch};
      kind_nxt = (photon_ch == det_r) ? KIND_SELECTED : KIND_OTHER;
    end else if (is_overflow) begin
      kind_nxt = KIND_OVERFLOW;
      code_nxt = '0;
    end else if (is_ignored) begin
      kind_nxt = KIND_IGNORED;
      code_nxt = '0;
      tick_nxt = '0;
    end

    accum_nxt = (s1_valid_r && s1_advance && is_overflow) ? tick_sum : accum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      accum_r     <= '0;
      mode_r      <= MODE_SINGLE_T2;
      det_r       <= DETECTOR_CHANNEL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DECODER_MODE) begin
          mode_r <= decoder_mode_t'(cfg_data[MODE_W-1:0]);
        end else if (cfg_index == REG_DETECTOR_CHANNEL) begin
          det_r <= cfg_data[CHAN_W-1:0];
        end
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
      accum_r <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rec_r <= in_tdata;
    end
    if (s1_advance && s1_valid_r) begin
      out_kind_r <= kind_nxt;
      out_tick_r <= tick_nxt;
      out_code_r <= code_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_code_r, out_tick_r, out_kind_r};

endmodule
